/* rtl/kclp_pkg.sv */
// ----------------------------------------------------------------------------
// Key combination long-press detector package
// Shared widths, register indexes, notice codes, opcodes and the timer command type.
// ----------------------------------------------------------------------------
package kclp_pkg;

  localparam int unsigned MaxKeysDefault     = 4;
  localparam int unsigned NumKeyCodesDefault = 768;

  localparam int unsigned KeyCodeW    = 10;
  localparam int unsigned KeyCountW   = 3;
  localparam int unsigned HoldW       = 16;
  localparam int unsigned NumCodeRegs = 4;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned NoticeW     = 2;

  localparam logic [KeyCountW-1:0] KeyCountReset   = KeyCountW'(1);
  localparam logic [HoldW-1:0]     HoldTicksReset  = HoldW'(1000);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_COUNT   = 3'd0,
    CFG_KEY_CODE_A  = 3'd1,
    CFG_KEY_CODE_B  = 3'd2,
    CFG_KEY_CODE_C  = 3'd3,
    CFG_KEY_CODE_D  = 3'd4,
    CFG_HOLD_TICKS  = 3'd5,
    CFG_HOLD_ENABLE = 3'd6
  } cfg_idx_e;

  typedef enum logic [NoticeW-1:0] {
    NOTICE_NONE      = 2'd0,
    NOTICE_MATCHED   = 2'd1,
    NOTICE_UNMATCHED = 2'd2,
    NOTICE_EXPIRED   = 2'd3
  } notice_e;

  typedef enum logic {
    OP_KEY  = 1'b0,
    OP_TICK = 1'b1
  } opcode_e;

  // One processed item as seen by the hold timer.
  typedef struct packed {
    logic valid;
    logic tick;
    logic matched;
  } timer_cmd_t;

endpackage

/* rtl/kclp_slot_match.sv */
// ----------------------------------------------------------------------------
// Slot matcher
// Holds one pressed flag per combination slot and tests the combination.
// ----------------------------------------------------------------------------
module kclp_slot_match import kclp_pkg::*; #(
  parameter int unsigned MAX_KEYS      = MaxKeysDefault,
  parameter int unsigned NUM_KEY_CODES = NumKeyCodesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 key_evt_i,
  input  logic [KeyCodeW-1:0]  key_code_i,
  input  logic                 key_down_i,
  input  logic [KeyCodeW-1:0]  slot_code_i [NumCodeRegs],
  input  logic [KeyCountW-1:0] key_count_i,
  output logic                 matched_o
);

  logic [MAX_KEYS-1:0] pressed_q;
  logic [MAX_KEYS-1:0] pressed_d;
  logic [MAX_KEYS-1:0] slot_ok;
  logic                code_in_range;

  assign code_in_range = {1'b0, key_code_i} < (KeyCodeW+1)'(NUM_KEY_CODES);

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_slot
    logic [KeyCodeW-1:0] code;
    if (i < NumCodeRegs) begin : g_reg
      assign code = slot_code_i[i];
    end else begin : g_zero
      // Slots past the code registers listen to key code zero.
      assign code = '0;
    end

    assign pressed_d[i] = (key_evt_i && code_in_range && code == key_code_i) ?
                          key_down_i : pressed_q[i];
    // A slot at or past the key count does not take part in the match.
    assign slot_ok[i]   = pressed_d[i] || (int'(key_count_i) <= i);
  end

  assign matched_o = &slot_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= '0;
    end else begin
      pressed_q <= pressed_d;
    end
  end

endmodule

/* rtl/kclp_hold_timer.sv */
// ----------------------------------------------------------------------------
// Hold timer
// Loads on a match while enabled and stopped, cancels on a mismatch and counts ticks down to expiry.
// ----------------------------------------------------------------------------
module kclp_hold_timer import kclp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  timer_cmd_t       cmd_i,
  input  logic [HoldW-1:0] hold_ticks_i,
  input  logic             hold_enable_i,
  output notice_e          notice_o,
  output logic             running_o
);

  logic [HoldW-1:0] left_q, left_d;
  logic             active_q, active_d;

  always_comb begin
    left_d   = left_q;
    active_d = active_q;
    notice_o = NOTICE_NONE;
    if (cmd_i.valid) begin
      if (cmd_i.tick) begin
        if (active_q) begin
          if (left_q < HoldW'(2)) begin
            left_d   = '0;
            active_d = 1'b0;
            notice_o = NOTICE_EXPIRED;
          end else begin
            left_d = left_q - HoldW'(1);
          end
        end
      end else if (cmd_i.matched) begin
        notice_o = NOTICE_MATCHED;
        // A running timer keeps counting; it is not reloaded.
        if (hold_enable_i && !active_q) begin
          left_d   = (hold_ticks_i == '0) ? HoldW'(1) : hold_ticks_i;
          active_d = 1'b1;
        end
      end else begin
        notice_o = NOTICE_UNMATCHED;
        left_d   = '0;
        active_d = 1'b0;
      end
    end
  end

  assign running_o = active_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      active_q <= 1'b0;
    end else begin
      left_q   <= left_d;
      active_q <= active_d;
    end
  end

endmodule

/* rtl/key_combo_long_press_detector_core.sv */
// Flow: an accepted item waits in the input register and moves to the result
// register when that register is free or its result is being taken.
// Throughput: one item per cycle while the result does not stall; the slot
// compare and timer update are a single registered step between the registers.
// A stalled result holds the input register, which then stalls the input.
// Reset clears the pressed flags and the timer and loads register defaults.
// ----------------------------------------------------------------------------
// Key combination long-press detector
// Input register, slot matcher, hold timer and result register.
// ----------------------------------------------------------------------------
module key_combo_long_press_detector_core import kclp_pkg::*; #(
  parameter int unsigned MAX_KEYS      = MaxKeysDefault,
  parameter int unsigned NUM_KEY_CODES = NumKeyCodesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                opcode_i,
  input  logic [KeyCodeW-1:0] key_code_i,
  input  logic                key_down_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [NoticeW-1:0]  notice_o,
  output logic                timer_running_o
);

  // Configuration registers.
  logic [KeyCountW-1:0] key_count_q;
  logic [KeyCodeW-1:0]  key_code_q [NumCodeRegs];
  logic [HoldW-1:0]     hold_ticks_q;
  logic                 hold_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q   <= KeyCountReset;
      key_code_q    <= '{default: '0};
      hold_ticks_q  <= HoldTicksReset;
      hold_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_COUNT:   key_count_q   <= cfg_wdata_i[KeyCountW-1:0];
        CFG_KEY_CODE_A:  key_code_q[0] <= cfg_wdata_i[KeyCodeW-1:0];
        CFG_KEY_CODE_B:  key_code_q[1] <= cfg_wdata_i[KeyCodeW-1:0];
        CFG_KEY_CODE_C:  key_code_q[2] <= cfg_wdata_i[KeyCodeW-1:0];
        CFG_KEY_CODE_D:  key_code_q[3] <= cfg_wdata_i[KeyCodeW-1:0];
        CFG_HOLD_TICKS:  hold_ticks_q  <= cfg_wdata_i;
        CFG_HOLD_ENABLE: hold_enable_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic                in_valid_q, in_valid_d;
  logic                opcode_q;
  logic [KeyCodeW-1:0] key_code_in_q;
  logic                key_down_q;
  logic                in_accept;
  logic                fire;
  logic                out_free;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_valid_d = in_accept || (in_valid_q && !fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      opcode_q      <= opcode_i;
      key_code_in_q <= key_code_i;
      key_down_q    <= key_down_i;
    end
  end

  // Processing step.
  logic       key_evt;
  logic       matched;
  timer_cmd_t timer_cmd;
  notice_e    notice_d;
  logic       running_d;

  assign key_evt = fire && (opcode_q == OP_KEY);

  kclp_slot_match #(
    .MAX_KEYS      (MAX_KEYS),
    .NUM_KEY_CODES (NUM_KEY_CODES)
  ) u_slot_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_evt_i   (key_evt),
    .key_code_i  (key_code_in_q),
    .key_down_i  (key_down_q),
    .slot_code_i (key_code_q),
    .key_count_i (key_count_q),
    .matched_o   (matched)
  );

  assign timer_cmd.valid   = fire;
  assign timer_cmd.tick    = (opcode_q == OP_TICK);
  assign timer_cmd.matched = matched;

  kclp_hold_timer u_hold_timer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (timer_cmd),
    .hold_ticks_i  (hold_ticks_q),
    .hold_enable_i (hold_enable_q),
    .notice_o      (notice_d),
    .running_o     (running_d)
  );

  // Result register.
  logic               out_valid_q;
  logic [NoticeW-1:0] notice_q;
  logic               running_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= fire || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      notice_q  <= notice_d;
      running_q <= running_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign notice_o        = notice_q;
  assign timer_running_o = running_q;

  // Expiry and mismatch both leave the timer stopped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (notice_o == NOTICE_EXPIRED || notice_o == NOTICE_UNMATCHED)
    |-> !timer_running_o)
    else $error("timer reported running after expiry or mismatch");

  // A processed item always lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("processed item did not produce a result");

  // The input side only stalls when an item is waiting in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_o && out_stall_i)
    else $error("input stalled without a blocked item");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key combination long-press detector testbench
// Drives key events and ticks through the valid/stall input channel and
// checks every result against an in-bench model of the slot flags and hold
// timer. The sender idles in bursts and the receiver stalls on its own
// pattern. Registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import kclp_pkg::*;

  typedef struct packed {
    opcode_e               opcode;
    logic [KeyCodeW-1:0]   code;
    logic                  down;
  } key_event_t;

  typedef struct packed {
    notice_e notice;
    logic    running;
  } combo_status_t;

  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned PhaseItems = 250;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                opcode_i = 1'b0;
  logic [KeyCodeW-1:0] key_code_i = '0;
  logic                key_down_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [NoticeW-1:0]  notice_o;
  logic                timer_running_o;

  key_combo_long_press_detector_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .key_code_i     (key_code_i),
    .key_down_i     (key_down_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .notice_o       (notice_o),
    .timer_running_o(timer_running_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Model of the configuration and of the detector state.
  logic [KeyCountW-1:0] combo_len = KeyCountReset;
  logic [KeyCodeW-1:0]  combo_code [NumCodeRegs] = '{default: '0};
  logic [HoldW-1:0]     hold_len = HoldTicksReset;
  logic                 hold_en = 1'b0;
  logic                 slot_down [MaxKeysDefault] = '{default: 1'b0};
  logic [HoldW-1:0]     hold_cnt = '0;
  logic                 hold_run = 1'b0;

  key_event_t    queued_events [$];
  combo_status_t expected_status [$];
  int unsigned   staged_count = 0;
  int unsigned   bad_count = 0;
  int unsigned   quiet_cycles = 0;
  logic          event_taken = 1'b0;

  function automatic combo_status_t predict_status(key_event_t ev);
    combo_status_t st;
    int unsigned   active;
    logic          all_down;
    st.notice = NOTICE_NONE;
    if (ev.opcode == OP_TICK) begin
      if (hold_run) begin
        if (hold_cnt <= HoldW'(1)) begin
          hold_cnt = '0;
          hold_run = 1'b0;
          st.notice = NOTICE_EXPIRED;
        end else begin
          hold_cnt = hold_cnt - HoldW'(1);
        end
      end
    end else begin
      if (32'(ev.code) < NumKeyCodesDefault) begin
        for (int i = 0; i < MaxKeysDefault; i++) begin
          if (((i < NumCodeRegs) ? combo_code[i] : '0) == ev.code) slot_down[i] = ev.down;
        end
      end
      active = (32'(combo_len) > MaxKeysDefault) ? MaxKeysDefault : 32'(combo_len);
      all_down = 1'b1;
      for (int i = 0; i < active; i++) begin
        if (!slot_down[i]) all_down = 1'b0;
      end
      if (all_down) begin
        st.notice = NOTICE_MATCHED;
        if (hold_en && !hold_run) begin
          hold_cnt = (hold_len == '0) ? HoldW'(1) : hold_len;
          hold_run = 1'b1;
        end
      end else begin
        st.notice = NOTICE_UNMATCHED;
        hold_run = 1'b0;
        hold_cnt = '0;
      end
    end
    st.running = hold_run;
    return st;
  endfunction

  // Fills the bits above a register's width with noise; the block must drop them.
  function automatic logic [CfgDataW-1:0] with_junk(int unsigned width,
                                                    logic [CfgDataW-1:0] value);
    logic [CfgDataW-1:0] keep;
    keep = ~({CfgDataW{1'b1}} << width);
    return (CfgDataW'($urandom) & ~keep) | (value & keep);
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_KEY_COUNT:   combo_len = data[KeyCountW-1:0];
      CFG_KEY_CODE_A, CFG_KEY_CODE_B, CFG_KEY_CODE_C, CFG_KEY_CODE_D:
        combo_code[2'(idx - CFG_KEY_CODE_A)] = data[KeyCodeW-1:0];
      CFG_HOLD_TICKS:  hold_len = data[HoldW-1:0];
      CFG_HOLD_ENABLE: hold_en = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_event(input opcode_e op, input logic [KeyCodeW-1:0] code,
                            input logic down);
    key_event_t ev;
    ev.opcode = op;
    ev.code   = code;
    ev.down   = down;
    queued_events.push_back(ev);
    staged_count++;
  endtask

  task automatic push_key(input logic [KeyCodeW-1:0] code, input logic down);
    push_event(OP_KEY, code, down);
  endtask

  // Ticks carry random key fields, which the block must ignore.
  task automatic push_tick;
    push_event(OP_TICK, KeyCodeW'($urandom), 1'($urandom));
  endtask

  task automatic push_noise;
    push_event(opcode_e'($urandom_range(0, 1)), KeyCodeW'($urandom_range(0, 1023)),
               1'($urandom));
  endtask

  task automatic settle;
    while (queued_events.size() != 0 || expected_status.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic random_phase(input int unsigned n_items);
    int unsigned goal, active, pick, eff, n, j, tmp, i;
    int unsigned order [4];
    logic [CfgDataW-1:0] v;
    settle();
    v = CfgDataW'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) :
                                                $urandom_range(1, 4));
    write_reg(CFG_KEY_COUNT, with_junk(KeyCountW, v));
    for (i = 0; i < NumCodeRegs; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0 && i != 0) v = CfgDataW'(combo_code[$urandom_range(0, i - 1)]);
      else if (pick == 1) v = CfgDataW'($urandom_range(768, 1023));
      else if (pick == 2) v = ($urandom_range(0, 1) != 0) ? '0 : CfgDataW'(767);
      else v = CfgDataW'($urandom_range(0, 767));
      write_reg(CfgIdxW'(CFG_KEY_CODE_A) + CfgIdxW'(i), with_junk(KeyCodeW, v));
    end
    pick = $urandom_range(0, 7);
    if (pick == 0) v = '0;
    else if (pick == 1) v = CfgDataW'($urandom_range(13, 65535));
    else v = CfgDataW'($urandom_range(1, 12));
    write_reg(CFG_HOLD_TICKS, v);
    write_reg(CFG_HOLD_ENABLE, with_junk(1, CfgDataW'($urandom_range(0, 4) != 0)));
    if ($urandom_range(0, 3) == 0) write_reg(CfgIdxUnused, CfgDataW'($urandom));

    active = (32'(combo_len) > MaxKeysDefault) ? MaxKeysDefault : 32'(combo_len);
    goal = staged_count + n_items;
    while (staged_count < goal) begin
      if ($urandom_range(0, 4) != 0) begin
        // Press the combination in a random order, hold it, then let go of some of its keys.
        for (i = 0; i < 4; i++) order[i] = i;
        for (i = 3; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (i = 0; i < active; i++) begin
          push_key(combo_code[order[i]], 1'b1);
          if ($urandom_range(0, 3) == 0) push_key(KeyCodeW'($urandom), 1'($urandom));
        end
        if (active == 0) push_key(KeyCodeW'($urandom), 1'($urandom));
        eff = (hold_len == '0) ? 32'd1 : 32'(hold_len);
        n = $urandom_range(0, (eff > 28) ? 30 : eff + 2);
        for (i = 0; i < n; i++) begin
          push_tick();
          if ($urandom_range(0, 15) == 0) push_key(combo_code[$urandom_range(0, 3)], 1'b1);
        end
        for (i = 0; i < NumCodeRegs; i++) begin
          if ($urandom_range(0, 1) == 0) push_key(combo_code[i], 1'b0);
        end
      end else begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) push_noise();
      end
    end
  endtask

  // Sender: bursts of random length separated by random gaps. A presented
  // transfer is held until it is taken.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || event_taken) begin
      if (burst_left == 0 && gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (queued_events.size() != 0) begin
          opcode_i   <= queued_events[0].opcode;
          key_code_i <= queued_events[0].code;
          key_down_i <= queued_events[0].down;
          in_valid_i <= 1'b1;
          burst_left--;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: a duty pattern whose period and duty are redrawn when its age runs out.
  int unsigned stall_age = 0;
  int unsigned stall_period = 1;
  int unsigned stall_duty = 0;
  int unsigned stall_pos = 0;

  always @(negedge clk_i) begin
    if (stall_age == 0) begin
      stall_age = $urandom_range(16, 96);
      stall_period = $urandom_range(2, 12);
      stall_duty = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, stall_period - 1);
    end
    stall_age--;
    stall_pos = (stall_pos + 1) % stall_period;
    out_stall_i <= (stall_pos < stall_duty);
  end

  // Predicts on every input transfer and checks every output transfer.
  always @(posedge clk_i) begin
    key_event_t    ev;
    combo_status_t want;
    logic          took_in, took_out;
    if (rst_ni) begin
      took_in  = in_valid_i && !in_stall_o;
      took_out = out_valid_o && !out_stall_i;
      event_taken <= took_in;
      if (took_in) begin
        ev.opcode = opcode_e'(opcode_i);
        ev.code   = key_code_i;
        ev.down   = key_down_i;
        expected_status.push_back(predict_status(ev));
        void'(queued_events.pop_front());
      end
      if (took_out) begin
        if (expected_status.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("unexpected result: notice %0d running %0b", notice_o, timer_running_o);
        end else begin
          want = expected_status.pop_front();
          if (notice_o !== want.notice || timer_running_o !== want.running) begin
            bad_count++;
            if (bad_count <= 10)
              $display("mismatch at %0t: notice exp %0d got %0d, running exp %0b got %0b",
                       $realtime, want.notice, notice_o, want.running, timer_running_o);
          end
        end
      end
      quiet_cycles = (took_in || took_out) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int unsigned p;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: one slot, every code register zero, timer disabled.
    push_tick();
    push_key(10'd0, 1'b1);
    push_key(10'd1023, 1'b1);
    push_key(10'd768, 1'b0);
    push_key(10'd0, 1'b0);
    settle();

    // Two slots, a duplicate code, and a hold of zero that acts as one tick.
    write_reg(CFG_KEY_COUNT, with_junk(KeyCountW, CfgDataW'(2)));
    write_reg(CFG_KEY_CODE_A, with_junk(KeyCodeW, CfgDataW'(767)));
    write_reg(CFG_KEY_CODE_B, with_junk(KeyCodeW, CfgDataW'(5)));
    write_reg(CFG_KEY_CODE_C, CfgDataW'(767));
    write_reg(CFG_KEY_CODE_D, '0);
    write_reg(CFG_HOLD_TICKS, '0);
    write_reg(CFG_HOLD_ENABLE, with_junk(1, CfgDataW'(1)));
    push_key(10'd767, 1'b1);
    push_key(10'd5, 1'b1);
    push_key(10'd5, 1'b1);
    push_tick();
    push_tick();
    push_key(10'd767, 1'b1);
    push_key(10'd5, 1'b0);
    settle();

    // No active slots: every key event matches; a match mid-hold must not reload.
    write_reg(CFG_KEY_COUNT, '0);
    write_reg(CFG_HOLD_TICKS, CfgDataW'(3));
    push_key(10'd200, 1'b0);
    push_tick();
    push_key(10'd1, 1'b1);
    push_tick();
    push_tick();
    settle();

    // Count above the slot limit saturates; all codes equal; longest hold.
    write_reg(CFG_KEY_COUNT, CfgDataW'(7));
    for (p = 0; p < NumCodeRegs; p++)
      write_reg(CfgIdxW'(CFG_KEY_CODE_A) + CfgIdxW'(p), CfgDataW'(9));
    write_reg(CFG_HOLD_TICKS, 16'hFFFF);
    write_reg(CfgIdxUnused, 16'hFFFF);
    push_key(10'd9, 1'b1);
    push_tick();
    push_key(10'd9, 1'b0);
    settle();

    write_reg(CFG_KEY_COUNT, CfgDataW'(4));
    write_reg(CFG_HOLD_ENABLE, '0);
    push_key(10'd9, 1'b1);

    for (p = 0; p < RandomPhases; p++) random_phase(PhaseItems);
    settle();

    if (bad_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* key_combo_long_press_detector_core.f */
rtl/kclp_pkg.sv
rtl/kclp_slot_match.sv
rtl/kclp_hold_timer.sv
rtl/key_combo_long_press_detector_core.sv
sim/testbench.sv
